FILE: sv/ffa_pkg.sv
// ----------------------------------------------------------------------------
// ffa_pkg
// Shared constants, table entry type and controller/datapath interface types
// for the first-fit heap block allocator.
// ----------------------------------------------------------------------------
package ffa_pkg;

   localparam int MAX_BLOCKS     = 64;
   localparam int IDX_W          = $clog2(MAX_BLOCKS);
   localparam int CNT_W          = $clog2(MAX_BLOCKS + 1);
   localparam int PREALLOC_BYTES = 131072;
   localparam int HEAP_BYTES     = 16777216;
   localparam int PRE_BRK        = (PREALLOC_BYTES < HEAP_BYTES) ? PREALLOC_BYTES : HEAP_BYTES;
   localparam int HDR_BYTES      = 24;
   localparam int ALIGN_BYTES    = 8;
   localparam int SPLIT_SLACK    = HDR_BYTES + 8;
   localparam int BYTES_MAX      = 16777216;

   localparam logic [1:0] REQ_ALLOC  = 2'd0;
   localparam logic [1:0] REQ_ZALLOC = 2'd1;
   localparam logic [1:0] REQ_FREE   = 2'd2;
   localparam logic [1:0] REQ_UNUSED = 2'd3;

   localparam logic [2:0] OUT_GRANT   = 3'd0;
   localparam logic [2:0] OUT_ROUTE   = 3'd1;
   localparam logic [2:0] OUT_ZERO    = 3'd2;
   localparam logic [2:0] OUT_FREED   = 3'd3;
   localparam logic [2:0] OUT_IGNORED = 3'd4;
   localparam logic [2:0] OUT_FULL    = 3'd5;

   localparam logic [1:0] CSR_MAP_THR  = 2'd0;
   localparam logic [1:0] CSR_ZERO_THR = 2'd1;

   localparam logic [24:0] MAP_THR_RST  = 25'd131072;
   localparam logic [24:0] ZERO_THR_RST = 25'd4096;

   typedef struct packed {
      logic [24:0] start;
      logic [24:0] size;
      logic        used;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef enum logic [4:0] {
      OP_NONE,
      OP_LOAD,
      OP_PAD,
      OP_RES_IGNORE,
      OP_RES_ZERO,
      OP_RES_ROUTE,
      OP_RES_FULL,
      OP_PRE0,
      OP_PRE1,
      OP_IDX_CLR,
      OP_READ,
      OP_FREE_HIT,
      OP_IDX_INC,
      OP_MRG_INIT,
      OP_MRG_TAKE,
      OP_MRG_STEP,
      OP_MRG_END,
      OP_SPLIT,
      OP_TAKE,
      OP_SH_READ,
      OP_SH_WRITE,
      OP_SH_END,
      OP_GROW,
      OP_APPEND,
      OP_EMIT
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } cmd_type;

   typedef struct packed {
      logic is_free;
      logic is_bad;
      logic zero;
      logic route;
      logic started;
      logic pre_full;
      logic pre_rem;
      logic idx_lt;
      logic hit;
      logic fit;
      logic split_ok;
      logic sh_more;
      logic grow;
      logic grow_full;
      logic app_full;
      logic out_free;
   } stat_type;

endpackage

FILE: sv/ffa_ram.sv
// ----------------------------------------------------------------------------
// ffa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ffa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/ffa_ctrl.sv
// ----------------------------------------------------------------------------
// ffa_ctrl
// Sequencer for the allocator: decodes a request and steps the datapath
// through free lookup, merge, first-fit search, split shift and tail cases.
// ----------------------------------------------------------------------------
module ffa_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  ffa_pkg::stat_type stat,
   output ffa_pkg::cmd_type  cmd
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PAD,
      ST_DECIDE,
      ST_PRE1,
      ST_FREE_RD,
      ST_FREE_CHK,
      ST_MRG_FIRST,
      ST_MRG_RD,
      ST_MRG_CHK,
      ST_SRCH_RD,
      ST_SRCH_CHK,
      ST_SH_RD,
      ST_SH_WR,
      ST_TAIL,
      ST_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      req_stall_ff;

   always_comb begin
      state_in = state_ff;
      cmd.op   = ffa_pkg::OP_NONE;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && !req_stall_ff) begin
               cmd.op   = ffa_pkg::OP_LOAD;
               state_in = ST_PAD;
            end
         end
         ST_PAD: begin
            cmd.op   = ffa_pkg::OP_PAD;
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            state_in = ST_DONE;
            if (stat.is_free) begin
               cmd.op   = ffa_pkg::OP_IDX_CLR;
               state_in = ST_FREE_RD;
            end else if (stat.is_bad) begin
               cmd.op = ffa_pkg::OP_RES_IGNORE;
            end else if (stat.zero) begin
               cmd.op = ffa_pkg::OP_RES_ZERO;
            end else if (stat.route) begin
               cmd.op = ffa_pkg::OP_RES_ROUTE;
            end else if (!stat.started) begin
               if (stat.pre_full) begin
                  cmd.op = ffa_pkg::OP_RES_FULL;
               end else begin
                  cmd.op = ffa_pkg::OP_PRE0;
                  if (stat.pre_rem) begin
                     state_in = ST_PRE1;
                  end
               end
            end else begin
               cmd.op   = ffa_pkg::OP_MRG_INIT;
               state_in = ST_MRG_FIRST;
            end
         end
         ST_PRE1: begin
            cmd.op   = ffa_pkg::OP_PRE1;
            state_in = ST_DONE;
         end
         ST_FREE_RD: begin
            if (stat.idx_lt) begin
               cmd.op   = ffa_pkg::OP_READ;
               state_in = ST_FREE_CHK;
            end else begin
               cmd.op   = ffa_pkg::OP_RES_IGNORE;
               state_in = ST_DONE;
            end
         end
         ST_FREE_CHK: begin
            if (stat.hit) begin
               cmd.op   = ffa_pkg::OP_FREE_HIT;
               state_in = ST_DONE;
            end else begin
               cmd.op   = ffa_pkg::OP_IDX_INC;
               state_in = ST_FREE_RD;
            end
         end
         ST_MRG_FIRST: begin
            cmd.op   = ffa_pkg::OP_MRG_TAKE;
            state_in = ST_MRG_RD;
         end
         ST_MRG_RD: begin
            if (stat.idx_lt) begin
               cmd.op   = ffa_pkg::OP_READ;
               state_in = ST_MRG_CHK;
            end else begin
               cmd.op   = ffa_pkg::OP_MRG_END;
               state_in = ST_SRCH_RD;
            end
         end
         ST_MRG_CHK: begin
            cmd.op   = ffa_pkg::OP_MRG_STEP;
            state_in = ST_MRG_RD;
         end
         ST_SRCH_RD: begin
            if (stat.idx_lt) begin
               cmd.op   = ffa_pkg::OP_READ;
               state_in = ST_SRCH_CHK;
            end else begin
               state_in = ST_TAIL;
            end
         end
         ST_SRCH_CHK: begin
            if (stat.fit && stat.split_ok) begin
               cmd.op   = ffa_pkg::OP_SPLIT;
               state_in = ST_SH_RD;
            end else if (stat.fit) begin
               cmd.op   = ffa_pkg::OP_TAKE;
               state_in = ST_DONE;
            end else begin
               cmd.op   = ffa_pkg::OP_IDX_INC;
               state_in = ST_SRCH_RD;
            end
         end
         ST_SH_RD: begin
            if (stat.sh_more) begin
               cmd.op   = ffa_pkg::OP_SH_READ;
               state_in = ST_SH_WR;
            end else begin
               cmd.op   = ffa_pkg::OP_SH_END;
               state_in = ST_DONE;
            end
         end
         ST_SH_WR: begin
            cmd.op   = ffa_pkg::OP_SH_WRITE;
            state_in = ST_SH_RD;
         end
         ST_TAIL: begin
            state_in = ST_DONE;
            if (stat.grow) begin
               cmd.op = stat.grow_full ? ffa_pkg::OP_RES_FULL : ffa_pkg::OP_GROW;
            end else begin
               cmd.op = stat.app_full ? ffa_pkg::OP_RES_FULL : ffa_pkg::OP_APPEND;
            end
         end
         ST_DONE: begin
            if (stat.out_free) begin
               cmd.op   = ffa_pkg::OP_EMIT;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         req_stall_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (cmd.op == ffa_pkg::OP_LOAD) begin
            req_stall_ff <= 1'b1;
         end else if (cmd.op == ffa_pkg::OP_EMIT) begin
            req_stall_ff <= 1'b0;
         end
      end
   end

   assign req_stall = req_stall_ff;

   a_stall_busy: assert property (@(posedge clock) disable iff (reset)
      req_stall_ff == (state_ff != ST_IDLE))
      else $error("stall out of step with controller state");

   a_done_emit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && stat.out_free) |=> (state_ff == ST_IDLE))
      else $error("result not issued from done state");

   a_load_pad: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == ffa_pkg::OP_LOAD) |=> (state_ff == ST_PAD))
      else $error("accepted request not sequenced");

endmodule

FILE: sv/ffa_dp.sv
// ----------------------------------------------------------------------------
// ffa_dp
// Allocator datapath: request registers, size padding, block table RAM,
// heap break and block count, thresholds, and result register.
// ----------------------------------------------------------------------------
module ffa_dp (
   input  logic              clock,
   input  logic              reset,
   input  ffa_pkg::cmd_type  cmd,
   output ffa_pkg::stat_type stat,
   input  logic [1:0]        req_type,
   input  logic [23:0]       req_byte_count,
   input  logic [15:0]       req_element_count,
   input  logic [23:0]       req_release_offset,
   input  logic              csr_valid,
   input  logic [1:0]        csr_index,
   input  logic [24:0]       csr_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [2:0]        rsp_outcome,
   output logic [23:0]       rsp_payload_offset,
   output logic [24:0]       rsp_block_bytes,
   output logic              rsp_clear_needed
);

   localparam int IW = ffa_pkg::IDX_W;
   localparam int CW = ffa_pkg::CNT_W;

   logic [1:0]  type_ff;
   logic [23:0] n_ff;
   logic [15:0] m_ff;
   logic [23:0] off_ff;
   logic [39:0] need_ff;
   logic [40:0] pad_ff;
   logic [24:0] mthr_ff, zthr_ff;
   logic [CW-1:0] idx_ff, w_ff, k_ff, cnt_ff;
   logic [24:0] brk_ff;
   logic        started_ff;
   ffa_pkg::entry_type cur_ff, last_ff;
   logic [2:0]  res_out_ff;
   logic [23:0] res_pay_ff;
   logic [24:0] res_bytes_ff;
   logic        res_clr_ff;
   logic        rsp_valid_ff;
   logic [2:0]  rsp_outcome_ff;
   logic [23:0] rsp_pay_ff;
   logic [24:0] rsp_bytes_ff;
   logic        rsp_clr_ff;

   ffa_pkg::entry_type rd, wdata;
   logic [ffa_pkg::ENTRY_W-1:0] rd_raw;
   logic          we, re;
   logic [IW-1:0] waddr, raddr;

   logic        zeroed;
   logic [24:0] pad25, thr, pre_brk, avail, dif, route_bytes;
   logic [39:0] slack;
   logic [CW-1:0] idx_nx, cnt_m1;

   assign zeroed      = (type_ff == ffa_pkg::REQ_ZALLOC);
   assign pad25       = pad_ff[24:0];
   assign thr         = zeroed ? zthr_ff : mthr_ff;
   assign pre_brk     = (pad25 > 25'(ffa_pkg::PRE_BRK)) ? pad25 : 25'(ffa_pkg::PRE_BRK);
   assign avail       = rd.size - 25'(ffa_pkg::HDR_BYTES);
   assign slack       = {15'd0, avail} - need_ff;
   assign dif         = pad25 - last_ff.size;
   assign idx_nx      = idx_ff + CW'(1);
   assign cnt_m1      = cnt_ff - CW'(1);
   assign rd          = ffa_pkg::entry_type'(rd_raw);
   assign route_bytes = (pad_ff > 41'(ffa_pkg::BYTES_MAX)) ? 25'(ffa_pkg::BYTES_MAX) : pad25;

   assign stat.is_free  = (type_ff == ffa_pkg::REQ_FREE);
   assign stat.is_bad   = (type_ff != ffa_pkg::REQ_ALLOC) && !zeroed && !stat.is_free;
   assign stat.zero     = (n_ff == 24'd0) || (zeroed && m_ff == 16'd0);
   assign stat.route    = (pad_ff >= {16'd0, thr}) || (pad_ff > 41'(ffa_pkg::BYTES_MAX));
   assign stat.started  = started_ff;
   assign stat.pre_full = pad_ff > 41'(ffa_pkg::HEAP_BYTES);
   assign stat.pre_rem  = pre_brk > pad25;
   assign stat.idx_lt   = idx_ff < cnt_ff;
   assign stat.hit      = rd.used && (rd.start + 25'(ffa_pkg::HDR_BYTES)) == {1'b0, off_ff};
   assign stat.fit      = !rd.used && (rd.size >= 25'(ffa_pkg::HDR_BYTES))
                          && ({15'd0, avail} >= need_ff);
   assign stat.split_ok = (slack >= 40'(ffa_pkg::SPLIT_SLACK))
                          && (cnt_ff < CW'(ffa_pkg::MAX_BLOCKS));
   assign stat.sh_more  = k_ff > idx_ff;
   assign stat.grow     = (cnt_ff != CW'(0)) && !last_ff.used && (pad25 > last_ff.size);
   assign stat.grow_full = ({1'b0, brk_ff} + {1'b0, dif}) > 26'(ffa_pkg::HEAP_BYTES);
   assign stat.app_full = (cnt_ff >= CW'(ffa_pkg::MAX_BLOCKS))
                          || (({1'b0, brk_ff} + {1'b0, pad25}) > 26'(ffa_pkg::HEAP_BYTES));
   assign stat.out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      we    = 1'b0;
      waddr = idx_ff[IW-1:0];
      wdata = rd;
      re    = 1'b0;
      raddr = idx_ff[IW-1:0];
      case (cmd.op)
         ffa_pkg::OP_PRE0: begin
            we    = 1'b1;
            waddr = IW'(0);
            wdata = '{start: 25'd0, size: pad25, used: 1'b1};
         end
         ffa_pkg::OP_PRE1: begin
            we    = 1'b1;
            waddr = IW'(1);
            wdata = '{start: pad25, size: pre_brk - pad25, used: 1'b0};
         end
         ffa_pkg::OP_READ: begin
            re = 1'b1;
         end
         ffa_pkg::OP_MRG_INIT: begin
            re    = 1'b1;
            raddr = IW'(0);
         end
         ffa_pkg::OP_SH_READ: begin
            re    = 1'b1;
            raddr = k_ff[IW-1:0];
         end
         ffa_pkg::OP_FREE_HIT: begin
            we    = 1'b1;
            wdata = '{start: rd.start, size: rd.size, used: 1'b0};
         end
         ffa_pkg::OP_MRG_STEP: begin
            we    = cur_ff.used || rd.used;
            waddr = w_ff[IW-1:0];
            wdata = cur_ff;
         end
         ffa_pkg::OP_MRG_END: begin
            we    = 1'b1;
            waddr = w_ff[IW-1:0];
            wdata = cur_ff;
         end
         ffa_pkg::OP_SPLIT: begin
            we    = 1'b1;
            wdata = '{start: rd.start, size: pad25, used: 1'b1};
         end
         ffa_pkg::OP_TAKE: begin
            we    = 1'b1;
            wdata = '{start: rd.start, size: rd.size, used: 1'b1};
         end
         ffa_pkg::OP_SH_WRITE: begin
            we    = 1'b1;
            waddr = IW'(k_ff + CW'(1));
            wdata = rd;
         end
         ffa_pkg::OP_SH_END: begin
            we    = 1'b1;
            waddr = idx_nx[IW-1:0];
            wdata = cur_ff;
         end
         ffa_pkg::OP_GROW: begin
            we    = 1'b1;
            waddr = cnt_m1[IW-1:0];
            wdata = '{start: last_ff.start, size: pad25, used: 1'b1};
         end
         ffa_pkg::OP_APPEND: begin
            we    = 1'b1;
            waddr = cnt_ff[IW-1:0];
            wdata = '{start: brk_ff, size: pad25, used: 1'b1};
         end
         default: begin
         end
      endcase
   end

   ffa_ram #(
      .WIDTH (ffa_pkg::ENTRY_W),
      .DEPTH (ffa_pkg::MAX_BLOCKS)
   ) u_table (
      .clock   (clock),
      .wr_en   (we),
      .wr_addr (waddr),
      .wr_data (wdata),
      .rd_en   (re),
      .rd_addr (raddr),
      .rd_data (rd_raw)
   );

   always_ff @(posedge clock) begin
      case (cmd.op)
         ffa_pkg::OP_LOAD: begin
            type_ff <= req_type;
            n_ff    <= req_byte_count;
            m_ff    <= req_element_count;
            off_ff  <= req_release_offset;
            need_ff <= (req_type == ffa_pkg::REQ_ZALLOC) ?
                       req_byte_count * req_element_count : {16'd0, req_byte_count};
         end
         ffa_pkg::OP_PAD: begin
            pad_ff <= ({1'b0, need_ff} + 41'(ffa_pkg::HDR_BYTES + ffa_pkg::ALIGN_BYTES - 1))
                      & ~41'(ffa_pkg::ALIGN_BYTES - 1);
         end
         ffa_pkg::OP_RES_IGNORE: begin
            res_out_ff   <= ffa_pkg::OUT_IGNORED;
            res_pay_ff   <= 24'd0;
            res_bytes_ff <= 25'd0;
            res_clr_ff   <= 1'b0;
         end
         ffa_pkg::OP_RES_ZERO: begin
            res_out_ff   <= ffa_pkg::OUT_ZERO;
            res_pay_ff   <= 24'd0;
            res_bytes_ff <= 25'd0;
            res_clr_ff   <= 1'b0;
         end
         ffa_pkg::OP_RES_FULL: begin
            res_out_ff   <= ffa_pkg::OUT_FULL;
            res_pay_ff   <= 24'd0;
            res_bytes_ff <= 25'd0;
            res_clr_ff   <= 1'b0;
         end
         ffa_pkg::OP_RES_ROUTE: begin
            res_out_ff   <= ffa_pkg::OUT_ROUTE;
            res_pay_ff   <= 24'd0;
            res_bytes_ff <= route_bytes;
            res_clr_ff   <= zeroed;
         end
         ffa_pkg::OP_FREE_HIT: begin
            res_out_ff   <= ffa_pkg::OUT_FREED;
            res_pay_ff   <= 24'd0;
            res_bytes_ff <= 25'd0;
            res_clr_ff   <= 1'b0;
         end
         ffa_pkg::OP_PRE0: begin
            res_out_ff   <= ffa_pkg::OUT_GRANT;
            res_pay_ff   <= 24'(ffa_pkg::HDR_BYTES);
            res_bytes_ff <= pad25;
            res_clr_ff   <= zeroed;
         end
         ffa_pkg::OP_SPLIT: begin
            cur_ff       <= '{start: rd.start + pad25, size: rd.size - pad25, used: 1'b0};
            res_out_ff   <= ffa_pkg::OUT_GRANT;
            res_pay_ff   <= 24'(rd.start + 25'(ffa_pkg::HDR_BYTES));
            res_bytes_ff <= pad25;
            res_clr_ff   <= zeroed;
         end
         ffa_pkg::OP_TAKE: begin
            res_out_ff   <= ffa_pkg::OUT_GRANT;
            res_pay_ff   <= 24'(rd.start + 25'(ffa_pkg::HDR_BYTES));
            res_bytes_ff <= rd.size;
            res_clr_ff   <= zeroed;
         end
         ffa_pkg::OP_GROW: begin
            res_out_ff   <= ffa_pkg::OUT_GRANT;
            res_pay_ff   <= 24'(last_ff.start + 25'(ffa_pkg::HDR_BYTES));
            res_bytes_ff <= pad25;
            res_clr_ff   <= zeroed;
         end
         ffa_pkg::OP_APPEND: begin
            res_out_ff   <= ffa_pkg::OUT_GRANT;
            res_pay_ff   <= 24'(brk_ff + 25'(ffa_pkg::HDR_BYTES));
            res_bytes_ff <= pad25;
            res_clr_ff   <= zeroed;
         end
         ffa_pkg::OP_MRG_TAKE: begin
            cur_ff <= rd;
         end
         ffa_pkg::OP_MRG_STEP: begin
            if (!cur_ff.used && !rd.used) begin
               cur_ff.size <= cur_ff.size + rd.size;
            end else begin
               cur_ff <= rd;
            end
         end
         ffa_pkg::OP_IDX_INC: begin
            last_ff <= rd;
         end
         default: begin
         end
      endcase
      if (cmd.op == ffa_pkg::OP_EMIT) begin
         rsp_outcome_ff <= res_out_ff;
         rsp_pay_ff     <= res_pay_ff;
         rsp_bytes_ff   <= res_bytes_ff;
         rsp_clr_ff     <= res_clr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         w_ff         <= '0;
         k_ff         <= '0;
         cnt_ff       <= '0;
         brk_ff       <= '0;
         started_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         mthr_ff      <= ffa_pkg::MAP_THR_RST;
         zthr_ff      <= ffa_pkg::ZERO_THR_RST;
      end else begin
         if (csr_valid && csr_index == ffa_pkg::CSR_MAP_THR) begin
            mthr_ff <= csr_data;
         end
         if (csr_valid && csr_index == ffa_pkg::CSR_ZERO_THR) begin
            zthr_ff <= csr_data;
         end
         if (cmd.op == ffa_pkg::OP_EMIT) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (cmd.op)
            ffa_pkg::OP_PRE0: begin
               started_ff <= 1'b1;
               brk_ff     <= pre_brk;
               cnt_ff     <= CW'(1);
            end
            ffa_pkg::OP_PRE1: begin
               cnt_ff <= CW'(2);
            end
            ffa_pkg::OP_IDX_CLR: begin
               idx_ff <= '0;
            end
            ffa_pkg::OP_IDX_INC: begin
               idx_ff <= idx_nx;
            end
            ffa_pkg::OP_MRG_INIT: begin
               idx_ff <= CW'(1);
               w_ff   <= '0;
            end
            ffa_pkg::OP_MRG_STEP: begin
               idx_ff <= idx_nx;
               if (cur_ff.used || rd.used) begin
                  w_ff <= w_ff + CW'(1);
               end
            end
            ffa_pkg::OP_MRG_END: begin
               cnt_ff <= w_ff + CW'(1);
               idx_ff <= '0;
            end
            ffa_pkg::OP_SPLIT: begin
               k_ff <= cnt_m1;
            end
            ffa_pkg::OP_SH_WRITE: begin
               k_ff <= k_ff - CW'(1);
            end
            ffa_pkg::OP_SH_END: begin
               cnt_ff <= cnt_ff + CW'(1);
            end
            ffa_pkg::OP_GROW: begin
               brk_ff <= brk_ff + dif;
            end
            ffa_pkg::OP_APPEND: begin
               brk_ff <= brk_ff + pad25;
               cnt_ff <= cnt_ff + CW'(1);
            end
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_outcome        = rsp_outcome_ff;
   assign rsp_payload_offset = rsp_pay_ff;
   assign rsp_block_bytes    = rsp_bytes_ff;
   assign rsp_clear_needed   = rsp_clr_ff;

   a_cnt_max: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(ffa_pkg::MAX_BLOCKS))
      else $error("block count beyond table depth");

   a_brk_max: assert property (@(posedge clock) disable iff (reset)
      {1'b0, brk_ff} <= 26'(ffa_pkg::HEAP_BYTES))
      else $error("heap break beyond heap");

   a_cold_empty: assert property (@(posedge clock) disable iff (reset)
      !started_ff |-> (cnt_ff == CW'(0) && brk_ff == 25'd0))
      else $error("table populated before heap start");

endmodule

FILE: sv/first_fit_heap_block_allocator_unit.sv
// ----------------------------------------------------------------------------
// first_fit_heap_block_allocator_unit
// First-fit heap block allocator with split and coalesce over a 64-entry
// address-ordered block table held in one RAM.
// ----------------------------------------------------------------------------
// Free scans the table entry by entry until its block is hit. An allocate after
// start runs merge, search and split shift passes over the block table, each
// reading its entries one at a time.
// One request at a time; next request taken the cycle after its result issues.
// Reset (synchronous): empty table, break zero, thresholds at defaults.
module first_fit_heap_block_allocator_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_type,
   input  logic [23:0] req_byte_count,
   input  logic [15:0] req_element_count,
   input  logic [23:0] req_release_offset,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_outcome,
   output logic [23:0] rsp_payload_offset,
   output logic [24:0] rsp_block_bytes,
   output logic        rsp_clear_needed,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [24:0] csr_data
);

   ffa_pkg::cmd_type  cmd;
   ffa_pkg::stat_type stat;

   assign csr_ready = !reset;

   ffa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   ffa_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .req_type           (req_type),
      .req_byte_count     (req_byte_count),
      .req_element_count  (req_element_count),
      .req_release_offset (req_release_offset),
      .csr_valid          (csr_valid && csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_outcome        (rsp_outcome),
      .rsp_payload_offset (rsp_payload_offset),
      .rsp_block_bytes    (rsp_block_bytes),
      .rsp_clear_needed   (rsp_clear_needed)
   );

endmodule
